>>> rtl/core/bmf_pkg.sv
// Shared types, constants and codes for the box mean filter.
`default_nettype none
package bmf_pkg;

    // Sample and configuration widths.
    localparam int DATA_W    = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int K_W       = 5;
    localparam int ROW_CNT_W = 10;

    // Default sizes of the line store.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 21;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 11'd512;
    localparam logic [K_W-1:0]   WINDOW_SIZE_RST = 5'd3;

    // Saturation value of the row counter.
    localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = '1;

    // One input request.
    typedef struct packed {
        logic [DATA_W-1:0] height;
        logic              frame_start;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic [DATA_W-1:0] smoothed;
        logic              row_last;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_START,
        S_DIV,
        S_FIN,
        S_EMIT,
        S_OUT,
        S_WRITE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/core/box_mean_filter_2d.sv
// Top level of the streaming k-by-k box mean filter.
// Takes one 16-bit height sample per request in raster order and keeps the last
// k-1 rows in a single-port line store. Each window term, the new sample or a
// value read from a stored row, is divided by k*k in the shared bit-serial
// divider; each result is then loaded into the output register, held by any
// output stall, and the next sample is taken while the last result waits in the
// output register. Rows before the window fills give no results; the h border
// columns of a row pass through unchanged, and the last result of a row carries
// row_last. The line store needs no clearing after reset.
`default_nettype none
module box_mean_filter_2d
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (WW > CFG_W) ? WW : CFG_W;
    localparam int RING  = MAX_WINDOW - 1;
    localparam int SW    = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int KKW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int HIW   = $clog2(RING);
    localparam int PW    = ((XW > K_W) ? XW : K_W) + 1;

    // Configuration registers.
    logic [CFG_W-1:0] image_width_reg;
    logic [K_W-1:0]   window_size_reg;

    // Stream position.
    logic [XW-1:0]        col_reg;
    logic [ROW_CNT_W-1:0] row_reg;
    logic [SW-1:0]        slot_reg;

    // Work registers of the request in progress.
    state_t            state_reg, state_next;
    logic [DATA_W-1:0] sample_reg;
    logic [XW-1:0]     x_reg;
    logic [XW-1:0]     wl_reg;
    logic              last_reg;
    logic              emit_reg;
    logic [SW-1:0]     slot_cur_reg;
    logic [SW-1:0]     centre_reg;
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    h_reg;
    logic [KKW-1:0]    kk_reg;
    logic [K_W-1:0]    j_reg;
    logic [DATA_W-1:0] vs_reg;
    logic [DATA_W-1:0] win_acc_reg;
    logic [DATA_W-1:0] win_reg;
    logic [XW-1:0]     c_reg;
    logic [XW-1:0]     end_reg;
    logic              inner_reg;
    logic [DATA_W-1:0] hist_reg [RING];

    // Output register.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Effective configuration.
    logic [CMPW-1:0] w_cl;
    logic [XW-1:0]   w_last;
    logic [K_W-1:0]  k_eff;
    logic [K_W-1:0]  h_eff;

    // Values derived at acceptance.
    logic                 in_acc;
    logic [XW-1:0]        col_eff;
    logic [ROW_CNT_W-1:0] row_eff;
    logic [SW-1:0]        slot_eff;
    logic [XW-1:0]        x_new;
    logic                 last_new;
    logic                 ready_new;
    logic                 past_h;

    // Emission and memory control.
    logic              inner_now;
    logic              out_free;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_rdata;
    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic              div_done;
    logic [DATA_W-1:0] div_q;
    logic [DATA_W-1:0] hist_rd;

    // Slot of the row that lies back rows above the current slot.
    function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] slot,
                                                input logic [K_W-1:0] back);
        logic [K_W:0] s;
        logic [K_W:0] b;
        logic [K_W:0] r;
        begin
            s = (K_W + 1)'(slot);
            b = (K_W + 1)'(back);
            r = (K_W + 1)'(RING);
            if (b >= r)
            begin
                b = b - r;
            end
            if (s >= b)
            begin
                slot_back = SW'(s - b);
            end
            else
            begin
                slot_back = SW'(s + r - b);
            end
        end
    endfunction

    // Address of a column within a ring slot.
    function automatic logic [AW-1:0] line_addr(input logic [SW-1:0] slot,
                                                input logic [XW-1:0] col);
        begin
            line_addr = AW'(AW'(slot) * AW'(MAX_WIDTH) + AW'(col));
        end
    endfunction

    // Clamp the configuration to the supported range and round the window down to an odd size.
    always_comb
    begin
        w_cl = CMPW'(image_width_reg);
        if (w_cl < CMPW'(2))
        begin
            w_cl = CMPW'(2);
        end
        else if (w_cl > CMPW'(MAX_WIDTH))
        begin
            w_cl = CMPW'(MAX_WIDTH);
        end
        w_last = XW'(w_cl - CMPW'(1));
        k_eff  = window_size_reg;
        if (k_eff == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (k_eff > K_W'(MAX_WINDOW))
        begin
            k_eff = K_W'(MAX_WINDOW);
        end
        if (!k_eff[0])
        begin
            k_eff = k_eff - K_W'(1);
        end
        h_eff = k_eff >> 1;
    end

    // Position of the incoming sample.
    always_comb
    begin
        in_acc    = in_valid && !in_stall;
        col_eff   = in_data.frame_start ? '0 : col_reg;
        row_eff   = in_data.frame_start ? '0 : row_reg;
        slot_eff  = in_data.frame_start ? '0 : slot_reg;
        x_new     = (col_eff > w_last) ? w_last : col_eff;
        last_new  = x_new == w_last;
        ready_new = row_eff >= (ROW_CNT_W'(k_eff) - ROW_CNT_W'(1));
        past_h    = PW'(x_new) >= PW'(h_eff);
    end

    // Emission helpers.
    always_comb
    begin
        inner_now = (PW'(c_reg) >= PW'(h_reg))
                    && (PW'(c_reg) + PW'(h_reg) <= PW'(wl_reg));
        out_free  = !out_valid_reg || !out_stall;
        hist_rd   = hist_reg[HIW'(j_reg - K_W'(1))];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RST;
            window_size_reg <= WINDOW_SIZE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[K_W-1:0];
                default:         ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_RD;
            S_RD:    state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = (j_reg == k_reg - K_W'(1)) ? S_FIN : S_RD;
                end
            end
            S_FIN:   state_next = emit_reg ? S_EMIT : S_WRITE;
            S_EMIT:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = (c_reg == end_reg) ? S_WRITE : S_EMIT;
                end
            end
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory and divider control.
    always_comb
    begin
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = line_addr(slot_cur_reg, x_reg);
        div_start    = 1'b0;
        div_dividend = (j_reg == '0) ? sample_reg : mem_rdata;
        case (state_reg)
            S_RD:
            begin
                mem_re   = j_reg != '0;
                mem_addr = line_addr(slot_back(slot_cur_reg, j_reg), x_reg);
            end
            S_START:
            begin
                div_start = 1'b1;
            end
            S_EMIT:
            begin
                mem_re   = !inner_now;
                mem_addr = line_addr(centre_reg, c_reg);
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                if (last_new)
                begin
                    col_reg  <= '0;
                    slot_reg <= (slot_eff == SW'(RING - 1)) ? '0 : slot_eff + SW'(1);
                    row_reg  <= (row_eff == ROW_CNT_MAX) ? row_eff : row_eff + 1'b1;
                end
                else
                begin
                    col_reg  <= x_new + XW'(1);
                    slot_reg <= slot_eff;
                    row_reg  <= row_eff;
                end
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg   <= in_data.height;
            x_reg        <= x_new;
            wl_reg       <= w_last;
            last_reg     <= last_new;
            emit_reg     <= ready_new && (past_h || last_new);
            slot_cur_reg <= slot_eff;
            centre_reg   <= slot_back(slot_eff, h_eff);
            k_reg        <= k_eff;
            h_reg        <= h_eff;
            kk_reg       <= KKW'(KKW'(k_eff) * KKW'(k_eff));
            j_reg        <= '0;
            vs_reg       <= '0;
            win_acc_reg  <= '0;
            c_reg        <= past_h ? XW'(PW'(x_new) - PW'(h_eff)) : '0;
            end_reg      <= (last_new || !past_h) ? x_new : XW'(PW'(x_new) - PW'(h_eff));
        end
        // Accumulate one window term and one stored column sum.
        if (state_reg == S_DIV && div_done)
        begin
            vs_reg <= vs_reg + div_q;
            if (j_reg != '0)
            begin
                win_acc_reg <= win_acc_reg + hist_rd;
            end
            j_reg <= j_reg + K_W'(1);
        end
        // Close the column sum and shift the column history.
        if (state_reg == S_FIN)
        begin
            win_reg     <= win_acc_reg + vs_reg;
            hist_reg[0] <= vs_reg;
            for (int i = 1; i < RING; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        if (state_reg == S_EMIT)
        begin
            inner_reg <= inner_now;
        end
        // Load one result.
        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg.smoothed <= inner_reg ? win_reg : mem_rdata;
            out_data_reg.row_last <= last_reg && (c_reg == x_reg);
            c_reg                 <= c_reg + XW'(1);
        end
    end

    bmf_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (sample_reg),
        .rdata (mem_rdata)
    );

    bmf_div #(
        .VW (KKW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (kk_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

>>> rtl/core/bmf_line_mem.sv
// Single-port line store with a registered read port.
`default_nettype none
module bmf_line_mem
    import bmf_pkg::*;
#(
    parameter int DEPTH = 20480,
    parameter int AW    = 15
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/core/bmf_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module bmf_div
    import bmf_pkg::*;
#(
    parameter int VW = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [VW-1:0]     divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quotient
);

    localparam int CW = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DATA_W-1:0] dq_reg;
    logic [VW-1:0]     rem_reg;
    logic [VW-1:0]     dvs_reg;
    logic [VW:0]       rem_sh;
    logic              fits;

    // One trial subtraction.
    always_comb
    begin
        rem_sh = {rem_reg, dq_reg[DATA_W-1]};
        fits   = rem_sh >= {1'b0, dvs_reg};
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DATA_W-2:0], fits};
            rem_reg <= fits ? VW'(rem_sh - {1'b0, dvs_reg}) : VW'(rem_sh);
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

>>> tb/box_mean_filter_2d_tb.sv
// Self-checking testbench for the streaming box mean filter: random bursts, stalls and checks.
`timescale 1ns / 1ps
module box_mean_filter_2d_tb;
    import bmf_pkg::*;

    localparam int MW = 1024;
    localparam int MK = 21;
    localparam int RING = MK - 1;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    box_mean_filter_2d DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow state of the filter.
    logic [15:0] rows_seen [RING*MW];
    int unsigned col_pos, row_pos, slot_pos;
    int unsigned vsum_hist [MK];
    int unsigned width_reg, ksize_reg;

    in_item_t  pending_samples[$];
    out_item_t expected_pixels[$];
    int mismatches;
    int samples_sent, pixels_checked;
    bit stim_done, hold_off;

    function automatic int unsigned back_slot(int unsigned back);
        return (slot_pos + RING - (back % RING)) % RING;
    endfunction

    // Computes the pixels that one accepted sample releases and updates the shadow state.
    task automatic predict_pixels(in_item_t req);
        int unsigned w, k, h, kk, x, vs, c, first, v, base;
        bit last_col;
        out_item_t px;
        w = (width_reg < 2) ? 2 : (width_reg > MW ? MW : width_reg);
        k = (ksize_reg < 1) ? 1 : (ksize_reg > MK ? MK : ksize_reg);
        if (k % 2 == 0) k = k - 1;
        h = k / 2;
        kk = k * k;
        if (req.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
            slot_pos = 0;
        end
        x = (col_pos > w - 1) ? w - 1 : col_pos;
        last_col = (x == w - 1);
        vs = req.height / kk;
        for (int j = 1; j < k; j++)
            vs += rows_seen[back_slot(j) * MW + x] / kk;
        for (int j = MK - 1; j > 0; j--)
            vsum_hist[j] = vsum_hist[j - 1];
        vsum_hist[0] = vs;
        if (row_pos >= k - 1)
        begin
            base = back_slot(h) * MW;
            first = (x >= h) ? x - h : 0;
            for (c = first; c <= x; c++)
            begin
                if (!(c == first && x >= h) && !last_col)
                    break;
                if (c >= h && c + h <= w - 1)
                begin
                    v = 0;
                    for (int j = 0; j < k; j++)
                        v += vsum_hist[j];
                end
                else if (h == 0)
                    v = req.height;
                else
                    v = rows_seen[base + c];
                px.smoothed = v[15:0];
                px.row_last = last_col && (c == x);
                expected_pixels.push_back(px);
            end
        end
        rows_seen[slot_pos * MW + x] = req.height;
        if (last_col)
        begin
            col_pos = 0;
            slot_pos = (slot_pos + 1) % RING;
            if (row_pos < 1023) row_pos++;
        end
        else
            col_pos = x + 1;
    endtask

    // Driver: bursts of requests separated by random gaps.
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixels(in_data);
                samples_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                    gap_left--;
                if (pending_samples.size() > 0 && gap_left == 0 && !hold_off)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_samples.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls on its own pattern and checks each accepted pixel.
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_px;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected pixel %h row_last %b",
                                 out_data.smoothed, out_data.row_last);
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    pixels_checked++;
                    if (exp_px.smoothed !== out_data.smoothed
                        || exp_px.row_last !== out_data.row_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Pixel mismatch: expected %h/%b, got %h/%b",
                                     exp_px.smoothed, exp_px.row_last,
                                     out_data.smoothed, out_data.row_last);
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 20)
                out_stall <= 1'b0;
            else if (stall_phase < 40)
                out_stall <= ($urandom_range(0, 2) == 0);
            else
                out_stall <= (stall_phase % 5 < 2);
        end
    end

    // Waits until every queued sample is accepted and processed and every pixel has arrived.
    task automatic drain();
        while (pending_samples.size() > 0 || in_valid || in_stall
               || expected_pixels.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val & 11'h7FF;
        else
            ksize_reg = val & 5'h1F;
    endtask

    // Queues one frame of random heights; extreme values mixed in.
    task automatic queue_frame(int unsigned w, int unsigned rows);
        in_item_t s;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++)
            begin
                case ($urandom_range(0, 5))
                    0: s.height = 16'hFFFF;
                    1: s.height = 16'h0000;
                    default: s.height = 16'($urandom_range(0, 65535));
                endcase
                s.frame_start = (r == 0 && c == 0);
                pending_samples.push_back(s);
            end
    endtask

    // Stimulus sequence.
    initial
    begin
        in_item_t s;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        mismatches = 0;
        samples_sent = 0;
        pixels_checked = 0;
        stim_done = 0;
        hold_off = 0;
        col_pos = 0;
        row_pos = 0;
        slot_pos = 0;
        width_reg = IMAGE_WIDTH_RST;
        ksize_reg = WINDOW_SIZE_RST;
        for (int j = 0; j < MK; j++)
            vsum_hist[j] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: window of one on a 2-wide map, all-ones and all-zeros samples.
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_WINDOW_SIZE, 1);
        for (int i = 0; i < 6; i++)
        begin
            s.height = (i % 2) ? 16'hFFFF : 16'h0000;
            s.frame_start = (i == 0);
            pending_samples.push_back(s);
        end
        drain();

        // Directed: 3x3 window on 4-wide rows, all maximum heights.
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_WINDOW_SIZE, 3);
        for (int i = 0; i < 12; i++)
        begin
            s.height = 16'hFFFF;
            s.frame_start = (i == 0);
            pending_samples.push_back(s);
        end
        drain();

        // Narrow rows (width below the window) and an even window size; clamp of zero width.
        write_reg(REG_WINDOW_SIZE, 6);
        write_reg(REG_IMAGE_WIDTH, 0);
        queue_frame(2, 6);
        drain();

        // Random: several window sizes on small maps, pausing until the output drains.
        for (int p = 0; p < 3; p++)
        begin
            int unsigned w, k;
            k = 2 * $urandom_range(0, 2) + 1;
            w = $urandom_range(3, 5);
            write_reg(REG_WINDOW_SIZE, k);
            write_reg(REG_IMAGE_WIDTH, w);
            queue_frame(w, k + 1);
            if (p == 1)
            begin
                hold_off = 1;
                repeat (40) @(posedge clk);
                hold_off = 0;
            end
            drain();
        end

        // A width above the maximum clamps; then a small frame that continues past its rows.
        write_reg(REG_WINDOW_SIZE, 3);
        write_reg(REG_IMAGE_WIDTH, 2047);
        for (int i = 0; i < 10; i++)
        begin
            s.height = 16'($urandom_range(0, 65535));
            s.frame_start = (i == 0);
            pending_samples.push_back(s);
        end
        drain();
        write_reg(REG_IMAGE_WIDTH, 4);
        queue_frame(4, 4);
        for (int i = 0; i < 4; i++)
        begin
            s.height = 16'($urandom_range(0, 65535));
            s.frame_start = 1'b0;
            pending_samples.push_back(s);
        end
        drain();
        stim_done = 1;

        $display("Run covered %0d samples and %0d checked pixels", samples_sent,
                 pixels_checked);
        $display("Window sizes one to five and an even size, widths from both clamps.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bmf_pkg.sv
rtl/core/bmf_line_mem.sv
rtl/core/bmf_div.sv
rtl/core/box_mean_filter_2d.sv
tb/box_mean_filter_2d_tb.sv
